>>> hdl/jti_pkg.sv
// ----------------------------------------------------------------------------
// jti_pkg: shared types and constants of the joint trajectory interpolator
// Knot layout, status codes and function codes.
// ----------------------------------------------------------------------------
package jti_pkg;

  localparam int unsigned MAX_KNOTS_DEF = 64;
  localparam int unsigned JOINTS_DEF    = 6;
  localparam int unsigned JOINTS_MAX    = 6;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_EMPTY        = 2'd1;
  localparam logic [1:0] ST_BAD_INTERVAL = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one knot as it travels along the cell chain
  typedef struct packed {
    logic [31:0]                    t;
    logic [JOINTS_MAX-1:0][31:0]    pos;
  } knot_t;

endpackage

>>> hdl/jti_cell.sv
// ----------------------------------------------------------------------------
// jti_cell: one knot slot of the chain
// Holds one knot; passes it to the previous cell of the ring each shift cycle.
// ----------------------------------------------------------------------------
module jti_cell (
  input  logic           clk,
  input  logic           wr,
  input  logic           shift,
  input  jti_pkg::knot_t wr_knot,
  input  jti_pkg::knot_t prev_knot,
  output jti_pkg::knot_t knot
);
  import jti_pkg::*;

  // load writes, query rotates the ring one slot per cycle
  always_ff @(posedge clk) begin
    if (wr) begin
      knot <= wr_knot;
    end else if (shift) begin
      knot <= prev_knot;
    end
  end

endmodule

>>> hdl/jti_div.sv
// ----------------------------------------------------------------------------
// jti_div: serial restoring divider for the 16-bit fraction
// Computes (num << 16) / den for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jti_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);
  import jti_pkg::*;

  logic [32:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  // num < den always holds here, so the quotient fits 16 bits
  assign trial = {rem, 1'b0} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= {1'b0, num};
        dvs  <= den;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[31:0], 1'b0};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/joint_trajectory_interpolator_unit.sv
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator_unit: piecewise linear joint trajectory
// Knot table as a ring of cells, serial search, serial divide, blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/stall): func 0 loads one knot into knot_slot and
//   yields no item; func 1 queries the positions at query_time and yields
//   one output item (six positions and a status). The user must write
//   knot_count via cfg_we/cfg_data only while idle; the block does not check.
// Operation:
//   A query walks the ring of MAX_KNOTS cells, one slot per cycle, until the
//   ring is back in place. An empty table, an end clamp or a bad interval
//   then yields the item from the decision step through the output step. A
//   blend adds the divider launch, a serial divide and a multiply step and
//   an add step per joint. One query is in work at a time and the next item
//   is taken in the cycle after the output item leaves.
// Reset: clears the control state and knot_count; table contents are
//   undefined until written.
// Stall: a finished item stays in the output register until taken; the
//   block accepts no new item until then.
// ----------------------------------------------------------------------------
module joint_trajectory_interpolator_unit #(
  parameter int unsigned MAX_KNOTS = jti_pkg::MAX_KNOTS_DEF,
  parameter int unsigned JOINTS    = jti_pkg::JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [5:0]         knot_slot,
  input  logic [31:0]        knot_time,
  input  logic [31:0]        query_time,
  input  logic signed [31:0] pos_in0,
  input  logic signed [31:0] pos_in1,
  input  logic signed [31:0] pos_in2,
  input  logic signed [31:0] pos_in3,
  input  logic signed [31:0] pos_in4,
  input  logic signed [31:0] pos_in5,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_out0,
  output logic signed [31:0] pos_out1,
  output logic signed [31:0] pos_out2,
  output logic signed [31:0] pos_out3,
  output logic signed [31:0] pos_out4,
  output logic signed [31:0] pos_out5,
  output logic [1:0]         status
);
  import jti_pkg::*;

  localparam int unsigned CW = $clog2(MAX_KNOTS + 1);
  localparam int unsigned JW = $clog2(JOINTS_MAX + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state;
  logic [6:0]    knot_count;
  logic [CW-1:0] n;
  logic [CW-1:0] scan_idx;
  logic [31:0]   t_q;
  knot_t         first_k, last_k, lo_k, hi_k, prev_k;
  logic          found;
  logic [JW-1:0] jidx;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [15:0]   frac;
  logic          div_start, div_done;
  logic [15:0]   div_q;
  logic [JOINTS_MAX-1:0][31:0] res;
  logic [1:0]    res_status;

  knot_t chain [MAX_KNOTS];
  knot_t wr_k;
  logic  shift;
  logic  accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign shift    = (state == S_SCAN);

  always_comb begin
    wr_k.t   = knot_time;
    wr_k.pos = '0;
    wr_k.pos[0] = pos_in0;
    wr_k.pos[1] = pos_in1;
    wr_k.pos[2] = pos_in2;
    wr_k.pos[3] = pos_in3;
    wr_k.pos[4] = pos_in4;
    wr_k.pos[5] = pos_in5;
  end

  // ring of knot cells; cell 0 is the one the search looks at
  for (genvar c = 0; c < MAX_KNOTS; c++) begin : g_cell
    logic wr_c;
    assign wr_c = accept && (func == FUNC_LOAD) && ({26'd0, knot_slot} == 32'(c));
    jti_cell u_cell (
      .clk       (clk),
      .wr        (wr_c),
      .shift     (shift),
      .wr_knot   (wr_k),
      .prev_knot (chain[(c + 1) % MAX_KNOTS]),
      .knot      (chain[c])
    );
  end

  assign n = ({25'd0, knot_count} > 32'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : CW'(knot_count);

  jti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (t_q - lo_k.t),
    .den   (hi_k.t - lo_k.t),
    .done  (div_done),
    .quo   (div_q)
  );

  assign diff = $signed({hi_k.pos[jidx[$clog2(JOINTS_MAX)-1:0]][31],
                         hi_k.pos[jidx[$clog2(JOINTS_MAX)-1:0]]})
              - $signed({lo_k.pos[jidx[$clog2(JOINTS_MAX)-1:0]][31],
                         lo_k.pos[jidx[$clog2(JOINTS_MAX)-1:0]]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      knot_count <= 7'd0;
      out_valid  <= 1'b0;
      div_start  <= 1'b0;
      jidx       <= '0;
    end else begin
      if (div_start) div_start <= 1'b0;
      if (cfg_we) knot_count <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && func == FUNC_QUERY) begin
            t_q      <= query_time;
            scan_idx <= '0;
            found    <= 1'b0;
            res      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // chain[0] holds slot scan_idx this cycle
          if (scan_idx == '0) first_k <= chain[0];
          if (scan_idx == n - CW'(1)) last_k <= chain[0];
          if (!found && scan_idx != '0 && scan_idx < n && t_q < chain[0].t) begin
            found <= 1'b1;
            hi_k  <= chain[0];
            lo_k  <= prev_k;
          end
          prev_k <= chain[0];
          scan_idx <= scan_idx + CW'(1);
          if (scan_idx == CW'(MAX_KNOTS - 1)) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // decision step, then wait for the divider
          if (!div_start && !div_done && jidx != JW'(JOINTS_MAX)) begin
            if (n == '0) begin
              res_status <= ST_EMPTY;
              state <= S_OUT;
            end else if (t_q <= first_k.t) begin
              res <= first_k.pos;
              res_status <= ST_OK;
              state <= S_OUT;
            end else if (t_q >= last_k.t || !found) begin
              res <= last_k.pos;
              res_status <= ST_OK;
              state <= S_OUT;
            end else if (hi_k.t <= lo_k.t) begin
              res_status <= ST_BAD_INTERVAL;
              state <= S_OUT;
            end else begin
              div_start <= 1'b1;
              jidx <= JW'(JOINTS_MAX);
            end
          end else if (div_done) begin
            frac <= div_q;
            jidx <= '0;
            res_status <= ST_OK;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, frac});
          state <= S_ADD;
        end
        S_ADD: begin
          res[jidx[$clog2(JOINTS_MAX)-1:0]] <=
            lo_k.pos[jidx[$clog2(JOINTS_MAX)-1:0]] + prod[47:16];
          if (jidx == JW'(JOINTS - 1)) begin
            state <= S_OUT;
          end else begin
            jidx  <= jidx + JW'(1);
            state <= S_MUL;
          end
        end
        S_OUT: begin
          for (int j = 0; j < JOINTS_MAX; j++) begin
            if (j >= JOINTS) res[j] <= '0;
          end
          out_valid <= 1'b1;
          jidx  <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_out0 = res[0];
  assign pos_out1 = res[1];
  assign pos_out2 = res[2];
  assign pos_out3 = res[3];
  assign pos_out4 = res[4];
  assign pos_out5 = res[5];
  assign status   = res_status;

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status)))
    else $error("stalled item changed");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide step");
`endif

endmodule
